### rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_ALLOC   = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_RESIZE  = 3'd3;
  localparam logic [2:0] ACT_OWNER   = 3'd4;
  localparam logic [2:0] ACT_LARGEST = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_BADBLK = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_TOP  = 3'd4;

  localparam logic [15:0] BASE_RESET = 16'd4096;
  localparam logic [15:0] TOP_RESET  = 16'd40960;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] size_paras;
    logic [15:0] owner;
    logic [15:0] block_segment;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] segment;
    logic [15:0] paras;
  } rsp_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GO, S_PASS_RD, S_PASS_EV, S_PASS_FIN, S_DECIDE,
    S_INS_CHK, S_INS_RD, S_INS_WR, S_INS_NEW, S_INS_OLD,
    S_DROP_CHK, S_DROP_RD, S_DROP_WR, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_ALLOC_SCAN, PH_LARGEST, PH_OWNER, PH_FREE_FIND,
    PH_FREE_MERGE, PH_RS_MERGE, PH_RS_FINAL, PH_RS_DROP
  } phase_t;

endpackage

### rtl/first_fit_block_allocator.sv
// sequence: result word valid the cycle after accept for init or an unknown action; others
// walk the block table entry by entry and shift entries one by one,
// with one to three walks or shifts per word
// throughput: one word at a time; the next word is accepted the cycle after the result leaves
// reset: control, entry count and result clear; arena_base 4096, arena_top 40960
// table contents are undefined after reset and are never read before a format
module first_fit_block_allocator import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  entry_t tbl [MAX_BLOCKS];
  entry_t rdata;

  state_t state, state_next;
  phase_t phase;
  cmd_t   cq;
  rsp_t   res;
  logic [15:0] arena_base, arena_top;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] r, w, k, p, oidx, fidx;
  entry_t acc, new_ent, old_ent;
  logic [15:0] best, hdr, fsize, fowner, fhdr, nowner, nsize;
  logic found, ncap, ins_new, ins_grow;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata;
  entry_t e;
  logic merge_en, find_fit, find_seg, clr_owner, clr_idx;
  logic first, mergeable, last, emit_v;
  logic accept, cfg_wr, fmt_ok, full, absorb, alloc_split, rs_split;
  logic [15:0] avail;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_BASE) ? {16'd0, arena_base} :
                  (paddr == REG_TOP) ? {16'd0, arena_top} : 32'd0;

  assign cmd_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp = res;
  assign accept = cmd_valid && (state == S_IDLE);

  assign merge_en  = (phase != PH_ALLOC_SCAN) && (phase != PH_FREE_FIND);
  assign find_fit  = (phase == PH_ALLOC_SCAN);
  assign find_seg  = (phase == PH_FREE_FIND) || (phase == PH_RS_MERGE);
  assign clr_owner = (phase == PH_OWNER);
  assign clr_idx   = (phase == PH_FREE_MERGE);

  assign fmt_ok = arena_top > arena_base;
  assign full = count >= CNT_W'(MAX_BLOCKS);
  assign absorb = ncap && (nowner == 16'd0);
  assign avail = absorb ? fsize + 16'd1 + nsize : fsize;
  assign alloc_split = fsize > cq.size_paras;
  assign rs_split = avail > cq.size_paras;

  always_comb begin
    e = rdata;
    if ((clr_owner && rdata.owner == cq.owner) || (clr_idx && r == fidx)) begin
      e.owner = 16'd0;
    end
  end

  assign first = (r == '0);
  assign mergeable = merge_en && !first && acc.owner == 16'd0 && e.owner == 16'd0;
  assign last = ({1'b0, r} == count - CNT_W'(1));
  assign emit_v = (state == S_PASS_EV && !first && !mergeable) || (state == S_PASS_FIN);

  // table ports
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = r;
    case (state)
      S_IDLE: begin
        if (accept && cmd.action == ACT_INIT && fmt_ok) begin
          we = 1'b1;
          wdata = '{owner: 16'd0, size: arena_top - arena_base - 16'd1};
        end
      end
      S_PASS_EV, S_PASS_FIN: begin
        if (emit_v && merge_en) begin
          we = 1'b1;
          waddr = w;
          wdata = acc;
        end
      end
      S_INS_RD: raddr = k - IDX_W'(1);
      S_INS_WR: begin
        we = 1'b1;
        waddr = k;
        wdata = rdata;
      end
      S_INS_NEW: begin
        we = 1'b1;
        waddr = p;
        wdata = new_ent;
      end
      S_INS_OLD: begin
        we = 1'b1;
        waddr = oidx;
        wdata = old_ent;
      end
      S_DROP_RD: raddr = k + IDX_W'(1);
      S_DROP_WR: begin
        we = 1'b1;
        waddr = k;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[waddr] <= wdata;
    end
    rdata <= tbl[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_ALLOC, ACT_FREE, ACT_RESIZE, ACT_OWNER, ACT_LARGEST: state_next = S_GO;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_GO: state_next = (count == '0) ? S_DECIDE : S_PASS_RD;
      S_PASS_RD: state_next = S_PASS_EV;
      S_PASS_EV: state_next = last ? S_PASS_FIN : S_PASS_RD;
      S_PASS_FIN: state_next = S_DECIDE;
      S_DECIDE: begin
        case (phase)
          PH_ALLOC_SCAN: begin
            if (!found || (alloc_split && full)) state_next = S_GO;
            else if (alloc_split) state_next = S_INS_CHK;
            else state_next = S_INS_OLD;
          end
          PH_FREE_FIND: state_next = found ? S_GO : S_DONE;
          PH_RS_MERGE: begin
            if (!found || cq.size_paras > avail || (rs_split && !absorb && full)) begin
              state_next = S_DONE;
            end else if (rs_split) begin
              state_next = S_INS_CHK;
            end else if (absorb) begin
              state_next = S_INS_OLD;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_INS_CHK: begin
        if (k > p) state_next = S_INS_RD;
        else if (ins_new) state_next = S_INS_NEW;
        else state_next = S_INS_OLD;
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = S_INS_CHK;
      S_INS_NEW: state_next = S_INS_OLD;
      S_INS_OLD: begin
        case (phase)
          PH_RS_DROP: state_next = S_DROP_CHK;
          PH_RS_FINAL: state_next = S_GO;
          default: state_next = S_DONE;
        endcase
      end
      S_DROP_CHK: state_next = ({1'b0, k} + CNT_W'(1) < count) ? S_DROP_RD : S_DONE;
      S_DROP_RD: state_next = S_DROP_WR;
      S_DROP_WR: state_next = S_DROP_CHK;
      S_DONE: state_next = rsp_stall ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LARGEST;
      count <= '0;
      arena_base <= BASE_RESET;
      arena_top <= TOP_RESET;
      res <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        if (paddr[2]) arena_top <= pwdata[15:0];
        else arena_base <= pwdata[15:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cq <= cmd;
            res <= '0;
            case (cmd.action)
              ACT_INIT: begin
                if (fmt_ok) begin
                  count <= CNT_W'(1);
                  res.paras <= arena_top - arena_base - 16'd1;
                end else begin
                  count <= '0;
                  res.status <= ST_NOMEM;
                end
              end
              ACT_ALLOC: phase <= PH_ALLOC_SCAN;
              ACT_FREE: phase <= PH_FREE_FIND;
              ACT_RESIZE: phase <= PH_RS_MERGE;
              ACT_OWNER: phase <= PH_OWNER;
              ACT_LARGEST: phase <= PH_LARGEST;
              default: ;
            endcase
          end
        end
        S_GO: begin
          r <= '0;
          w <= '0;
          best <= '0;
          hdr <= arena_base;
          found <= 1'b0;
          ncap <= 1'b0;
        end
        S_PASS_EV: begin
          if (first || !mergeable) acc <= e;
          else acc.size <= acc.size + 16'd1 + e.size;
          r <= r + IDX_W'(1);
        end
        S_PASS_FIN: begin
          if (merge_en) count <= {1'b0, w} + CNT_W'(1);
        end
        S_DECIDE: begin
          case (phase)
            PH_ALLOC_SCAN: begin
              if (!found || (alloc_split && full)) begin
                phase <= PH_LARGEST;
                res.status <= found ? ST_FULL : ST_NOMEM;
              end else begin
                res.segment <= fhdr + 16'd1;
                res.paras <= cq.size_paras;
                new_ent <= '{owner: 16'd0, size: fsize - cq.size_paras - 16'd1};
                old_ent <= '{owner: cq.owner, size: cq.size_paras};
                oidx <= fidx;
                p <= fidx + IDX_W'(1);
                k <= count[IDX_W-1:0];
                ins_new <= 1'b1;
                ins_grow <= 1'b1;
              end
            end
            PH_FREE_FIND: begin
              if (found) phase <= PH_FREE_MERGE;
              else res.status <= ST_BADBLK;
            end
            PH_RS_MERGE: begin
              if (!found) begin
                res.status <= ST_BADBLK;
              end else if (cq.size_paras > avail) begin
                res.status <= ST_NOMEM;
                res.paras <= avail;
              end else if (rs_split && !absorb && full) begin
                res.status <= ST_FULL;
                res.paras <= avail;
              end else begin
                res.segment <= cq.block_segment;
                res.paras <= cq.size_paras;
                oidx <= fidx;
                p <= fidx + IDX_W'(1);
                new_ent <= '{owner: 16'd0, size: avail - cq.size_paras - 16'd1};
                ins_new <= 1'b1;
                if (rs_split) begin
                  phase <= PH_RS_FINAL;
                  old_ent <= '{owner: fowner, size: cq.size_paras};
                  k <= absorb ? fidx + IDX_W'(1) : count[IDX_W-1:0];
                  ins_grow <= !absorb;
                end else begin
                  phase <= PH_RS_DROP;
                  old_ent <= '{owner: fowner, size: avail};
                  ins_grow <= 1'b0;
                end
              end
            end
            PH_LARGEST: res.paras <= best;
            default: ;
          endcase
        end
        S_INS_WR: k <= k - IDX_W'(1);
        S_INS_NEW: begin
          if (ins_grow) count <= count + CNT_W'(1);
        end
        S_INS_OLD: k <= oidx + IDX_W'(1);
        S_DROP_CHK: begin
          if (!({1'b0, k} + CNT_W'(1) < count)) count <= count - CNT_W'(1);
        end
        S_DROP_WR: k <= k + IDX_W'(1);
        default: ;
      endcase

      // emitted entry of a walk
      if (emit_v) begin
        w <= w + IDX_W'(1);
        hdr <= hdr + 16'd1 + acc.size;
        if (acc.owner == 16'd0 && acc.size > best) best <= acc.size;
        if (!found && ((find_fit && acc.owner == 16'd0 && acc.size >= cq.size_paras) ||
                       (find_seg && hdr + 16'd1 == cq.block_segment))) begin
          found <= 1'b1;
          fidx <= w;
          fsize <= acc.size;
          fowner <= acc.owner;
          fhdr <= hdr;
        end else if (found && !ncap && w == fidx + IDX_W'(1)) begin
          ncap <= 1'b1;
          nowner <= acc.owner;
          nsize <= acc.size;
        end
      end
    end
  end

endmodule
